>>> rtl/egcd_pkg.sv
// Shared widths, types, codes and control structs for the extended gcd block.
package egcd_pkg;

  localparam int WIDTH        = 32;
  localparam int KW           = $clog2(WIDTH);
  localparam int CW           = WIDTH + 2;
  localparam int IN_DATA_W    = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 * WIDTH - 2;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_MOD     = 2'd1;
  localparam logic [1:0] ST_NOT_COPRIME = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_RALIGN,
    S_RSUB,
    S_EGINIT,
    S_ALIGN,
    S_SUB,
    S_FIXUP,
    S_SIGN,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RINIT,
    CMD_ALIGN,
    CMD_RSUB,
    CMD_SUB,
    CMD_EGINIT,
    CMD_FIXUP,
    CMD_SIGN
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic out_wr;
  } dp_ctrl_t;

  typedef struct packed {
    logic func;
    logic bad_mod;
    logic can_shift;
    logic k_zero;
    logic rem_zero;
    logic trivial;
  } dp_stat_t;

  typedef struct packed {
    logic [WIDTH-2:0] gcd;
    logic [WIDTH-1:0] u;
    logic [WIDTH-1:0] v;
    logic [WIDTH-2:0] inv;
    logic [1:0]       st;
  } result_t;

endpackage

>>> rtl/egcd_ctrl.sv
// Sequencer for the extended gcd datapath.
module egcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_free,
  input  egcd_pkg::dp_stat_t  stat,
  output egcd_pkg::dp_ctrl_t  ctl,
  output logic                in_ready
);
  import egcd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_START;
      S_START: begin
        priority if (stat.bad_mod) state_nxt = S_DONE;
        else if (stat.func)        state_nxt = S_RALIGN;
        else                       state_nxt = S_EGINIT;
      end
      S_RALIGN: if (!stat.can_shift) state_nxt = S_RSUB;
      S_RSUB:   if (stat.k_zero) state_nxt = S_EGINIT;
      S_EGINIT: state_nxt = stat.trivial ? S_FIXUP : S_ALIGN;
      S_ALIGN:  if (!stat.can_shift) state_nxt = S_SUB;
      S_SUB: begin
        if (stat.k_zero) state_nxt = stat.rem_zero ? S_FIXUP : S_ALIGN;
      end
      S_FIXUP:  state_nxt = S_SIGN;
      S_SIGN:   state_nxt = S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.cmd    = CMD_NONE;
    ctl.out_wr = 1'b0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctl.cmd = CMD_LOAD;
      end
      S_START:  if (!stat.bad_mod && stat.func) ctl.cmd = CMD_RINIT;
      S_RALIGN: ctl.cmd = CMD_ALIGN;
      S_RSUB:   ctl.cmd = CMD_RSUB;
      S_EGINIT: ctl.cmd = CMD_EGINIT;
      S_ALIGN:  ctl.cmd = CMD_ALIGN;
      S_SUB:    ctl.cmd = CMD_SUB;
      S_FIXUP:  ctl.cmd = CMD_FIXUP;
      S_SIGN:   ctl.cmd = CMD_SIGN;
      S_DONE:   ctl.out_wr = out_free;
      default:  ctl.cmd = CMD_NONE;
    endcase
  end

endmodule

>>> rtl/egcd_dp.sv
// Shift-subtract Euclid datapath with Bezout coefficient tracking.
module egcd_dp (
  input  logic                         clk,
  input  logic                         in_func,
  input  logic [egcd_pkg::WIDTH-1:0]   in_opa,
  input  logic [egcd_pkg::WIDTH-1:0]   in_opb,
  input  egcd_pkg::dp_ctrl_t           ctl,
  output egcd_pkg::dp_stat_t           stat,
  output egcd_pkg::result_t            result
);
  import egcd_pkg::*;

  logic                 func_r;
  logic [WIDTH-1:0]     opa_r, opb_r;
  logic [WIDTH-1:0]     a_r, b_r, bs_r;
  logic signed [CW-1:0] us_r, vs_r, u0_r, v0_r, u1_r, v1_r;
  logic [KW-1:0]        k_r;
  logic                 odd_r, sa_neg_r, sa_zero_r, sb_neg_r, sb_zero_r;

  logic                 ge, can_shift, k_zero, first_trivial;
  logic [WIDTH-1:0]     a_sub, mag_a, mag_b, eg_a, eg_b;
  logic signed [CW-1:0] u_sub, v_sub, n_ext, inv_full;

  always_comb begin
    ge        = (a_r >= bs_r);
    a_sub     = ge ? (a_r - bs_r) : a_r;
    u_sub     = ge ? (u0_r - us_r) : u0_r;
    v_sub     = ge ? (v0_r - vs_r) : v0_r;
    can_shift = ({bs_r, 1'b0} <= {1'b0, a_r});
    k_zero    = (k_r == '0);
    mag_a     = opa_r[WIDTH-1] ? (~opa_r + WIDTH'(1)) : opa_r;
    mag_b     = opb_r[WIDTH-1] ? (~opb_r + WIDTH'(1)) : opb_r;
    eg_a      = func_r ? opa_r : mag_a;
    eg_b      = func_r ? a_r : mag_b;
    first_trivial = (eg_b == '0) || (eg_a == eg_b);
  end

  assign stat.func      = func_r;
  assign stat.bad_mod   = func_r && (opa_r[WIDTH-1] || (opa_r == '0));
  assign stat.can_shift = can_shift;
  assign stat.k_zero    = k_zero;
  assign stat.rem_zero  = (a_sub == '0);
  assign stat.trivial   = first_trivial || (eg_a == '0);

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      CMD_LOAD: begin
        func_r <= in_func;
        opa_r  <= in_opa;
        opb_r  <= in_opb;
      end
      CMD_RINIT: begin
        a_r  <= mag_b;
        bs_r <= opa_r;
        k_r  <= '0;
      end
      CMD_ALIGN: begin
        if (can_shift) begin
          bs_r <= {bs_r[WIDTH-2:0], 1'b0};
          us_r <= us_r <<< 1;
          vs_r <= vs_r <<< 1;
          k_r  <= k_r + KW'(1);
        end
      end
      CMD_RSUB: begin
        a_r <= a_sub;
        if (!k_zero) begin
          bs_r <= bs_r >> 1;
          k_r  <= k_r - KW'(1);
        end
      end
      CMD_SUB: begin
        if (k_zero) begin
          // quotient done: rotate (a, b) and the coefficient pairs
          a_r   <= b_r;
          b_r   <= a_sub;
          bs_r  <= a_sub;
          u0_r  <= u1_r;
          v0_r  <= v1_r;
          u1_r  <= u_sub;
          v1_r  <= v_sub;
          us_r  <= u_sub;
          vs_r  <= v_sub;
          odd_r <= ~odd_r;
        end else begin
          a_r  <= a_sub;
          u0_r <= u_sub;
          v0_r <= v_sub;
          bs_r <= bs_r >> 1;
          us_r <= us_r >>> 1;
          vs_r <= vs_r >>> 1;
          k_r  <= k_r - KW'(1);
        end
      end
      CMD_EGINIT: begin
        sa_neg_r  <= !func_r && opa_r[WIDTH-1];
        sa_zero_r <= (opa_r == '0);
        sb_neg_r  <= opb_r[WIDTH-1];
        sb_zero_r <= (eg_b == '0);
        odd_r     <= 1'b0;
        priority if (first_trivial) begin
          a_r  <= eg_a;
          u0_r <= CW'(1);
          v0_r <= '0;
        end else if (eg_a == '0) begin
          a_r  <= eg_b;
          u0_r <= '0;
          v0_r <= CW'(1);
        end else begin
          a_r  <= eg_a;
          b_r  <= eg_b;
          bs_r <= eg_b;
          k_r  <= '0;
          u0_r <= CW'(1);
          v0_r <= '0;
          u1_r <= '0;
          v1_r <= CW'(1);
          us_r <= '0;
          vs_r <= CW'(1);
        end
      end
      CMD_FIXUP: begin
        // odd step count leaves u <= 0: move to the other solution
        if (odd_r) begin
          u0_r <= u0_r + u1_r;
          v0_r <= v0_r + v1_r;
        end
      end
      CMD_SIGN: begin
        u0_r <= sa_zero_r ? '0 : (sa_neg_r ? -u0_r : u0_r);
        v0_r <= sb_zero_r ? '0 : (sb_neg_r ? -v0_r : v0_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    n_ext    = {{(CW-WIDTH){opa_r[WIDTH-1]}}, opa_r};
    inv_full = (!v0_r[CW-1] && (v0_r != '0)) ? v0_r : (v0_r + n_ext);
    result.gcd = a_r[WIDTH-2:0];
    result.u   = u0_r[WIDTH-1:0];
    result.v   = v0_r[WIDTH-1:0];
    result.inv = '0;
    result.st  = ST_OK;
    if (stat.bad_mod) begin
      result.gcd = '0;
      result.u   = '0;
      result.v   = '0;
      result.st  = ST_BAD_MOD;
    end else if (func_r) begin
      if (a_r != WIDTH'(1)) begin
        result.st = ST_NOT_COPRIME;
      end else if (opa_r != WIDTH'(1)) begin
        result.inv = inv_full[WIDTH-2:0];
      end
    end
  end

endmodule

>>> rtl/extended_gcd_modular_inverse.sv
// Sequence per item: start, then (mode 1) reduction of k by n, then init, the Euclid steps,
// fixup, sign and done; each Euclid step is shift-subtract, one compare/subtract a cycle.
// Mode 1 reduces |k| by n in the same shift-subtract manner; a bad modulus goes from start to done.
// A new item is taken only after the current result has left done for the output register.
// in_tready is high only while idle; a full output register holds the sequencer in done,
// else the result waits there while the next item is taken. Reset (rst_n low, sync) idles all.
module extended_gcd_modular_inverse (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // fields from bit 0 up: operand_a, operand_b, zero pad
  input  logic [egcd_pkg::IN_DATA_W-1:0]    in_tdata,
  // fields from bit 0 up: func
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // fields from bit 0 up: gcd_value, coeff_u, coeff_v, inverse, zero pad
  output logic [egcd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // fields from bit 0 up: status
  output logic [1:0]                        out_tuser
);
  import egcd_pkg::*;

  dp_ctrl_t ctl;
  dp_stat_t stat;
  result_t  result;

  logic     out_valid_r;
  result_t  out_res_r;
  logic     out_free;

  // output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_tready;

  egcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_tready)
  );

  egcd_dp u_dp (
    .clk     (clk),
    .in_func (in_tuser),
    .in_opa  (in_tdata[WIDTH-1:0]),
    .in_opb  (in_tdata[2*WIDTH-1:WIDTH]),
    .ctl     (ctl),
    .stat    (stat),
    .result  (result)
  );

  // result holding stage: loaded on the final sequencer cycle, cleared on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_wr) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_wr) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                       out_res_r.inv, out_res_r.v, out_res_r.u, out_res_r.gcd};
  assign out_tuser  = out_res_r.st;

endmodule
